/* sv/smq_pkg.sv */
// ----------------------------------------------------------------------------
// smq_pkg
// Types and fixed constants shared by the shared-buffer multi-queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

  // Item field widths
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned QID_W      = 2;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STATUS_W   = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic init_wr;   // write one entry of the link clearing pass
    logic accept;    // input transfer this cycle
    logic rd_slot;   // read link and data at the addressed slot
    logic commit;    // update pointers and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_last; // clearing pass at last entry
    logic out_busy;  // result register holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

/* sv/smq_ctrl.sv */
// ----------------------------------------------------------------------------
// smq_ctrl
// Sequencer: link clearing pass, then accept / slot read / commit per item.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  smq_pkg::sts_t      sts,
  output smq_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RDS  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RDS;
        end
      end
      S_RDS: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.init_wr = (state_r == S_INIT);
  assign cmd.accept  = (state_r == S_IDLE) && in_tvalid;
  assign cmd.rd_slot = (state_r == S_RDS);
  assign cmd.commit  = (state_r == S_WR) && !sts.out_busy;

  a_accept_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_RDS))
    else $error("accepted item not followed by slot read");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDS) |=> (state_r == S_WR))
    else $error("slot read not followed by commit state");

  a_init_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_INIT) && !sts.init_last) |=> (state_r == S_INIT))
    else $error("clearing pass left early");

endmodule

`default_nettype wire

/* sv/smq_dp.sv */
// ----------------------------------------------------------------------------
// smq_dp
// Datapath: slot link/data memories, queue head/tail memories, free list
// pointer, occupancy bits and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_dp #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  smq_pkg::cmd_t                            cmd,
  output smq_pkg::sts_t                            sts,
  input  wire logic [smq_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [smq_pkg::OUT_TDATA_W-1:0]          out_tdata
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned XW = QW + smq_pkg::QID_W;
  localparam logic [LW-1:0] END_MARK = LW'(SLOTS);

  // Memories
  logic [LW-1:0]              link_mem [SLOTS];
  logic [smq_pkg::DATA_W-1:0] data_mem [SLOTS];
  logic [SW-1:0]              head_mem [QUEUES];
  logic [SW-1:0]              tail_mem [QUEUES];

  // Control / pointer state
  logic [LW-1:0]     free_head_r;
  logic [QUEUES-1:0] nonempty_r;
  logic [SW-1:0]     init_cnt_r;

  // Latched item
  logic [smq_pkg::FUNC_W-1:0] func_r;
  logic [smq_pkg::QID_W-1:0]  qid_r;
  logic [smq_pkg::DATA_W-1:0] din_r;

  // Registered reads
  logic [SW-1:0]              head_rd_r;
  logic [SW-1:0]              tail_rd_r;
  logic [LW-1:0]              link_rd_r;
  logic [smq_pkg::DATA_W-1:0] data_rd_r;

  // Result register
  logic                         out_valid_r;
  logic [smq_pkg::STATUS_W-1:0] out_status_r;
  logic [smq_pkg::DATA_W-1:0]   out_data_r;

  // Input field unpack
  logic [smq_pkg::FUNC_W-1:0] in_func;
  logic [smq_pkg::QID_W-1:0]  in_qid;
  logic [smq_pkg::DATA_W-1:0] in_data;
  assign in_func = in_tdata[0];
  assign in_qid  = in_tdata[2:1];
  assign in_data = in_tdata[34:3];

  logic [XW-1:0] in_qx;
  logic [QW-1:0] in_qi;
  assign in_qx = {{QW{1'b0}}, in_qid};
  assign in_qi = in_qx[QW-1:0];

  logic [XW-1:0] qx;
  logic [QW-1:0] qi;
  logic          q_ok;
  assign qx   = {{QW{1'b0}}, qid_r};
  assign qi   = qx[QW-1:0];
  assign q_ok = (qx < XW'(QUEUES));

  logic free_ok;
  logic q_ne;
  logic enq_ok;
  logic deq_ok;
  logic [SW-1:0] free_slot;
  assign free_ok   = (free_head_r != END_MARK);
  assign free_slot = free_head_r[SW-1:0];
  assign q_ne      = q_ok && nonempty_r[qi];
  assign enq_ok    = cmd.commit && (func_r == smq_pkg::FUNC_ENQ) && q_ok && free_ok;
  assign deq_ok    = cmd.commit && (func_r == smq_pkg::FUNC_DEQ) && q_ne;

  // Slot address for the read cycle: head for dequeue, free head for enqueue
  logic [SW-1:0] rd_addr;
  always_comb begin
    if (func_r == smq_pkg::FUNC_DEQ) begin
      rd_addr = head_rd_r;
    end else if (free_ok) begin
      rd_addr = free_slot;
    end else begin
      rd_addr = '0;
    end
  end

  // Single link write port: clearing pass, tail link on enqueue, free push on dequeue
  logic          link_we;
  logic [SW-1:0] link_wa;
  logic [LW-1:0] link_wd;
  always_comb begin
    link_we = 1'b0;
    link_wa = init_cnt_r;
    link_wd = LW'(init_cnt_r) + LW'(1);
    if (cmd.init_wr) begin
      link_we = 1'b1;
    end else if (enq_ok && q_ne) begin
      link_we = 1'b1;
      link_wa = tail_rd_r;
      link_wd = free_head_r;
    end else if (deq_ok) begin
      link_we = 1'b1;
      link_wa = head_rd_r;
      link_wd = free_head_r;
    end
  end

  // Head write: first slot of an empty queue, or advance past the dequeued slot
  logic          head_we;
  logic [SW-1:0] head_wd;
  always_comb begin
    head_we = 1'b0;
    head_wd = free_slot;
    if (enq_ok && !q_ne) begin
      head_we = 1'b1;
    end else if (deq_ok && (head_rd_r != tail_rd_r)) begin
      head_we = 1'b1;
      head_wd = link_rd_r[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (enq_ok) begin
      data_mem[free_slot] <= din_r;
      tail_mem[qi]        <= free_slot;
    end
    if (head_we) begin
      head_mem[qi] <= head_wd;
    end
    if (cmd.accept) begin
      head_rd_r <= head_mem[in_qi];
      tail_rd_r <= tail_mem[in_qi];
    end
    if (cmd.rd_slot) begin
      link_rd_r <= link_mem[rd_addr];
      data_rd_r <= data_mem[rd_addr];
    end
  end

  // Item latch and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      qid_r  <= in_qid;
      din_r  <= in_data;
    end
    if (cmd.commit) begin
      if (func_r == smq_pkg::FUNC_ENQ) begin
        out_status_r <= enq_ok ? smq_pkg::ST_OK : smq_pkg::ST_FULL;
        out_data_r   <= '0;
      end else begin
        out_status_r <= deq_ok ? smq_pkg::ST_OK : smq_pkg::ST_EMPTY;
        out_data_r   <= deq_ok ? data_rd_r : '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      nonempty_r  <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_cnt_r <= init_cnt_r + SW'(1);
      end
      if (enq_ok) begin
        free_head_r    <= link_rd_r;
        nonempty_r[qi] <= 1'b1;
      end else if (deq_ok) begin
        free_head_r <= LW'(head_rd_r);
        if (head_rd_r == tail_rd_r) begin
          nonempty_r[qi] <= 1'b0;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.init_last = (init_cnt_r == SW'(SLOTS - 1));
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(smq_pkg::OUT_TDATA_W - smq_pkg::STATUS_W - smq_pkg::DATA_W){1'b0}},
                       out_data_r, out_status_r};

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_tready))
    else $error("result overwritten before transfer");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= END_MARK)
    else $error("free list head out of range");

endmodule

`default_nettype wire

/* sv/shared_buffer_multi_queue_unit.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// Several FIFO queues kept as linked lists in one shared slot store.
// ----------------------------------------------------------------------------
// QUEUES queues share SLOTS 32-bit slots. Each input transfer is one operation
// on one queue: an enqueue takes the first slot of the free list, stores the
// data and links it behind the queue's tail; a dequeue unlinks the head slot,
// returns its data and pushes the slot back on the free list. Every operation
// gives exactly one result: status ok, full (no free slot, or a queue number
// not below QUEUES on enqueue) or empty (queue holds nothing, or a queue number
// not below QUEUES on dequeue), and the dequeued data on an ok dequeue, else 0.
// After reset the unit builds the free list in the link memory, with in_tready
// low. After that each operation runs as a sequence: the accept cycle reads the
// queue's head and tail, the slot read step reads the slot's link and data, and
// the commit step writes the pointers and loads the result register; the commit
// step is held only while the result register still holds an untaken result.
// The one-write-port link memory and its registered read set this sequence.
// A new operation is accepted while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_buffer_multi_queue_unit #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Operation stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [0] func, [2:1] queue_id, [34:3] data_in, [39:35] zero
  input  wire logic [smq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] status, [33:2] data_out, [39:34] zero
  output logic [smq_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  // Command and status between sequencer and datapath
  smq_pkg::cmd_t cmd;
  smq_pkg::sts_t sts;

  // Sequencer: clearing pass, then accept / slot read / commit
  smq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Memories, pointers and result register
  smq_dp #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* test/tb_shared_buffer_multi_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue_unit
// Self-checking bench for the shared-buffer multi-queue unit.
// ----------------------------------------------------------------------------
// Drives enqueue and dequeue operations over the input stream and checks every
// result against a local linked-list predictor of the four queues and the free
// list. A short table covers the data extremes, underflow on empty queues and
// overflow once all slots are taken; random traffic with shifting
// enqueue/dequeue mixes then fills and drains the store many times. Both
// stream sides idle at random, the receiver holds off once for a long stretch
// and the sender pauses once until every result is back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shared_buffer_multi_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned QUEUES      = 4;
  localparam logic [4:0]  END_MARK    = 5'(SLOTS);
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DIR_ROWS    = 17;

  // One result as the unit reports it
  typedef struct packed {
    logic [smq_pkg::STATUS_W-1:0] st;
    logic [smq_pkg::DATA_W-1:0]   dout;
  } op_result_t;

  // One row of the directed table; reps repeats the same operation
  typedef struct packed {
    logic [smq_pkg::FUNC_W-1:0]   f;
    logic [smq_pkg::QID_W-1:0]    q;
    logic [smq_pkg::DATA_W-1:0]   d;
    logic [7:0]                   reps;
    logic                         typed;
    logic [smq_pkg::STATUS_W-1:0] st;
    logic [smq_pkg::DATA_W-1:0]   dout;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [smq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [smq_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Predictor state: slot store, links, queue pointers and free list
  logic [smq_pkg::DATA_W-1:0] slot_val  [SLOTS];
  logic [4:0]                 slot_next [SLOTS];
  logic [4:0]                 q_head    [QUEUES];
  logic [3:0]                 q_tail    [QUEUES];
  logic [4:0]                 free_ptr;

  op_result_t  pending_results[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          quiet;       // no idling on either side
  bit          hold_start;  // ask the receiver for a long hold-off
  int unsigned hold_left;

  // Directed table. Typed rows carry an expectation that follows directly
  // from the steps above them; the others rely on the predictor.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // dequeue from empty queues right after reset
    '{smq_pkg::FUNC_DEQ, 2'd0, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_EMPTY, 32'h0},
    '{smq_pkg::FUNC_DEQ, 2'd3, 32'hFFFF_FFFF, 8'd1, 1'b1, smq_pkg::ST_EMPTY, 32'h0},
    // data extremes through queue 0, in order, then underflow again
    '{smq_pkg::FUNC_ENQ, 2'd0, 32'h7FFF_FFFF, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_ENQ, 2'd0, 32'h8000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_DEQ, 2'd0, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h7FFF_FFFF},
    '{smq_pkg::FUNC_DEQ, 2'd0, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h8000_0000},
    '{smq_pkg::FUNC_DEQ, 2'd0, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_EMPTY, 32'h0},
    // take every slot, then overflow
    '{smq_pkg::FUNC_ENQ, 2'd3, 32'hFFFF_FFFF, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_ENQ, 2'd1, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_ENQ, 2'd2, 32'hA5A5_A5A5, 8'd14, 1'b1, smq_pkg::ST_OK,   32'h0},
    '{smq_pkg::FUNC_ENQ, 2'd0, 32'h1234_5678, 8'd1, 1'b1, smq_pkg::ST_FULL,  32'h0},
    // free one slot, reuse it, overflow again
    '{smq_pkg::FUNC_DEQ, 2'd3, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'hFFFF_FFFF},
    '{smq_pkg::FUNC_ENQ, 2'd0, 32'h0000_FFFF, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_ENQ, 2'd1, 32'h0000_0001, 8'd1, 1'b1, smq_pkg::ST_FULL,  32'h0},
    '{smq_pkg::FUNC_DEQ, 2'd1, 32'h0000_0000, 8'd1, 1'b1, smq_pkg::ST_OK,    32'h0},
    // partial drain, checked by the predictor
    '{smq_pkg::FUNC_DEQ, 2'd2, 32'h0000_0000, 8'd4, 1'b0, smq_pkg::ST_OK,    32'h0},
    '{smq_pkg::FUNC_DEQ, 2'd0, 32'h0000_0000, 8'd1, 1'b0, smq_pkg::ST_OK,    32'h0}
  };

  shared_buffer_multi_queue_unit #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Put the predictor in its post-reset state: all slots chained on the
  // free list, every queue empty.
  function automatic void clear_queue_state();
    for (int i = 0; i < SLOTS; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = 5'(i + 1);
    end
    slot_next[SLOTS-1] = END_MARK;
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = END_MARK;
      q_tail[i] = '0;
    end
    free_ptr = '0;
  endfunction

  // Apply one operation to the predictor and return the result it gives.
  function automatic op_result_t predict_queue_op(input logic [smq_pkg::FUNC_W-1:0] f,
                                                  input logic [smq_pkg::QID_W-1:0] q,
                                                  input logic [smq_pkg::DATA_W-1:0] d);
    op_result_t res;
    logic [3:0] slot;
    logic [4:0] nxt;
    res.st   = smq_pkg::ST_OK;
    res.dout = '0;
    if (f == smq_pkg::FUNC_ENQ) begin
      if (q >= QUEUES || free_ptr >= SLOTS) begin
        res.st = smq_pkg::ST_FULL;
      end else begin
        // pop the free list, link behind the tail
        slot     = free_ptr[3:0];
        free_ptr = slot_next[slot];
        if (free_ptr >= SLOTS) free_ptr = END_MARK;
        if (q_head[q] >= SLOTS) begin
          q_head[q] = {1'b0, slot};
        end else begin
          slot_next[q_tail[q]] = {1'b0, slot};
        end
        slot_next[slot] = END_MARK;
        q_tail[q]       = slot;
        slot_val[slot]  = d;
      end
    end else begin
      if (q >= QUEUES || q_head[q] >= SLOTS) begin
        res.st = smq_pkg::ST_EMPTY;
      end else begin
        // unlink the head, push it on the front of the free list
        slot            = q_head[q][3:0];
        nxt             = slot_next[slot];
        q_head[q]       = (nxt < SLOTS) ? nxt : END_MARK;
        res.dout        = slot_val[slot];
        slot_next[slot] = free_ptr;
        free_ptr        = {1'b0, slot};
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [smq_pkg::DATA_W-1:0] got,
                                 input logic [smq_pkg::DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // Offer one operation and wait for its transfer. Hold tvalid high across
  // back-to-back items; drop it only for a random idle cycle.
  task automatic send_op(input logic [smq_pkg::FUNC_W-1:0] f,
                         input logic [smq_pkg::QID_W-1:0] q,
                         input logic [smq_pkg::DATA_W-1:0] d, input logic typed,
                         input logic [smq_pkg::STATUS_W-1:0] t_st,
                         input logic [smq_pkg::DATA_W-1:0] t_dout);
    op_result_t res;
    while (!quiet && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, d, q, f};
    do @(posedge clk); while (!in_tready);
    res = predict_queue_op(f, q, d);
    if (typed) begin
      res.st   = t_st;
      res.dout = t_dout;
    end
    pending_results.push_back(res);
  endtask

  // Pick a data word: mostly random, now and then an extreme value.
  function automatic logic [smq_pkg::DATA_W-1:0] pick_data();
    logic [smq_pkg::DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0: v = 32'h0000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  // Receiver: random backpressure, with one long hold-off counted here.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 8);
      end
    end
  end

  // Compare each result transfer with the oldest pending expectation.
  always @(posedge clk) begin
    op_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_tdata), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] != want.st)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.st));
        if (out_tdata[33:2] != want.dout)
          report_mismatch("data_out", out_tdata[33:2], want.dout);
        if (out_tdata[39:34] != '0)
          report_mismatch("padding", 32'(out_tdata[39:34]), '0);
      end
    end
  end

  // Watchdog: fail and end the run once cycle_count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sender: reset, directed table, then random traffic.
  initial begin
    int unsigned enq_pct;
    int unsigned phase;
    logic [smq_pkg::QID_W-1:0] hot_q;
    logic [smq_pkg::QID_W-1:0] q;
    logic [smq_pkg::FUNC_W-1:0] f;
    err_count   = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    hold_start  = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    clear_queue_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        send_op(dir_tab[r].f, dir_tab[r].q, dir_tab[r].d, dir_tab[r].typed,
                dir_tab[r].st, dir_tab[r].dout);
      end
    end

    // Random traffic in phases of 100 items: the enqueue share swings between
    // filling, draining and balanced, and every other phase favors one queue.
    hot_q = '0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      phase = i / 100;
      case (phase % 3)
        0: enq_pct = 75;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      if (i % 100 == 0) hot_q = smq_pkg::QID_W'($urandom_range(QUEUES - 1));
      quiet = (i >= 450 && i < 650);
      // let the unit back up behind a stalled receiver
      if (i == 300) hold_start = 1'b1;
      // stop offering until every result is back
      if (i == 800) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      f = ($urandom_range(99) < enq_pct) ? smq_pkg::FUNC_ENQ : smq_pkg::FUNC_DEQ;
      if (phase % 2 == 1 && $urandom_range(99) < 70) q = hot_q;
      else q = smq_pkg::QID_W'($urandom_range(QUEUES - 1));
      send_op(f, q, pick_data(), 1'b0, smq_pkg::ST_OK, '0);
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    // drain, then give the unit time to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
